// File: hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package qrs_pkg;

	localparam int VAL_W         = 32;
	localparam int FRAC_BITS_DEF = 16;

	// square root result width and radicand width
	localparam int SQ_W  = VAL_W + 1;
	localparam int RAD_W = 2 * SQ_W;
	// divisor and dividend magnitude widths
	localparam int DEN_W = VAL_W + 1;
	localparam int NUM_W = VAL_W + 2;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_LINEAR  = 3'd1,
		KIND_TWO     = 3'd2,
		KIND_DOUBLE  = 3'd3,
		KIND_COMPLEX = 3'd4
	} kind_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] coef_a;
		logic signed [VAL_W-1:0] coef_b;
		logic signed [VAL_W-1:0] coef_c;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]              root_kind;
		logic signed [VAL_W-1:0] first_value;
		logic signed [VAL_W-1:0] second_value;
		logic                    saturated;
	} out_beat_t;

	// carried alongside the square root chain
	typedef struct packed {
		kind_t                   kind;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
		logic signed [VAL_W-1:0] c;
	} sq_side_t;

	// carried alongside the divider chain
	typedef struct packed {
		kind_t kind;
		logic  use1;
		logic  use2;
		logic  neg1;
		logic  neg2;
	} dv_side_t;

	function automatic logic [VAL_W-1:0] mag_f(input logic signed [VAL_W-1:0] v);
		logic [VAL_W-1:0] r;
		r = v[VAL_W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

// File: hw/rtl/qrs_sqrt_cell.sv
// One cell of the square root chain: retires one root bit per cycle
// while en is high. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt_cell import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid,
	input  logic [SQ_W+1:0]   rem,
	input  logic [SQ_W-1:0]   root,
	input  logic [RAD_W-1:0]  rad,
	input  sq_side_t          side,
	output logic              valid_q,
	output logic [SQ_W+1:0]   rem_q,
	output logic [SQ_W-1:0]   root_q,
	output logic [RAD_W-1:0]  rad_q,
	output sq_side_t          side_q
);

	logic [SQ_W+3:0] rem_x;
	logic [SQ_W+3:0] trial;
	logic [SQ_W+3:0] diff;
	logic            ge;

	always_comb begin
		rem_x = {rem, rad[RAD_W-1 -: 2]};
		trial = {2'b00, root, 2'b01};
		diff  = rem_x - trial;
		ge    = rem_x >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[SQ_W+1:0] : rem_x[SQ_W+1:0];
			root_q <= {root[SQ_W-2:0], ge};
			rad_q  <= {rad[RAD_W-3:0], 2'b00};
			side_q <= side;
		end
	end

endmodule

// File: hw/rtl/qrs_div_cell.sv
// One cell of the dual divider chain: one quotient bit per lane per cycle
// while en is high. Depends on qrs_pkg; both lanes share one divisor.
`timescale 1ns / 1ps

module qrs_div_cell import qrs_pkg::*; #(
	parameter int ND_W = NUM_W + FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid,
	input  logic [DEN_W-1:0]  dm,
	input  dv_side_t          side,
	input  logic [DEN_W-1:0]  rem1,
	input  logic [DEN_W-1:0]  rem2,
	input  logic [ND_W-1:0]   dvd1,
	input  logic [ND_W-1:0]   dvd2,
	input  logic [ND_W-1:0]   quo1,
	input  logic [ND_W-1:0]   quo2,
	output logic              valid_q,
	output logic [DEN_W-1:0]  dm_q,
	output dv_side_t          side_q,
	output logic [DEN_W-1:0]  rem1_q,
	output logic [DEN_W-1:0]  rem2_q,
	output logic [ND_W-1:0]   dvd1_q,
	output logic [ND_W-1:0]   dvd2_q,
	output logic [ND_W-1:0]   quo1_q,
	output logic [ND_W-1:0]   quo2_q
);

	logic [DEN_W:0] t1, t2, d1, d2;
	logic           ge1, ge2;

	always_comb begin
		t1  = {rem1, dvd1[ND_W-1]};
		t2  = {rem2, dvd2[ND_W-1]};
		d1  = t1 - {1'b0, dm};
		d2  = t2 - {1'b0, dm};
		ge1 = t1 >= {1'b0, dm};
		ge2 = t2 >= {1'b0, dm};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_q   <= dm;
			side_q <= side;
			rem1_q <= ge1 ? d1[DEN_W-1:0] : t1[DEN_W-1:0];
			rem2_q <= ge2 ? d2[DEN_W-1:0] : t2[DEN_W-1:0];
			dvd1_q <= {dvd1[ND_W-2:0], 1'b0};
			dvd2_q <= {dvd2[ND_W-2:0], 1'b0};
			quo1_q <= {quo1[ND_W-2:0], ge1};
			quo2_q <= {quo2[ND_W-2:0], ge2};
		end
	end

endmodule

// File: hw/rtl/quadratic_root_solver_top.sv
// Top level of the quadratic root solver: front stages, square root chain,
// dual divider chain and output register. Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
//
// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients with FRAC_BITS
// fraction bits. One beat enters per cycle and one result beat leaves per beat,
// in order, while no result beat is stalled. The front stages form the exact
// discriminant, a chain of VAL_W+1 cells retires one root bit each, a register
// stage forms numerators and divisor, a chain of VAL_W+2+FRAC_BITS cells retires
// one quotient bit of both divisions each, and a last stage clamps into the
// output register. The whole pipe holds while a result beat is stalled.
`timescale 1ns / 1ps

module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_beat_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_beat_t rsp
);

	localparam int ND_W  = NUM_W + FRAC_BITS;
	localparam int D_W   = 2 * VAL_W + 2;
	localparam int NS_W  = VAL_W + 3;

	logic en;
	logic rsp_valid_q;
	out_beat_t rsp_q;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stage 1: magnitudes and products
	logic                    v_s1;
	logic signed [VAL_W-1:0] a_s1, b_s1, c_s1;
	logic [2*VAL_W-1:0]      bb_s1, ac_s1;
	logic                    same_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= req.coef_a;
			b_s1    <= req.coef_b;
			c_s1    <= req.coef_c;
			bb_s1   <= (2*VAL_W)'(mag_f(req.coef_b)) * (2*VAL_W)'(mag_f(req.coef_b));
			ac_s1   <= (2*VAL_W)'(mag_f(req.coef_a)) * (2*VAL_W)'(mag_f(req.coef_c));
			same_s1 <= req.coef_a[VAL_W-1] == req.coef_c[VAL_W-1];
		end
	end

	// stage 2: discriminant, class and radicand
	logic signed [D_W-1:0] disc;
	kind_t                 kind_c;
	logic                  v_s2;
	logic [RAD_W-1:0]      rad_s2;
	sq_side_t              side_s2;

	always_comb begin
		if (same_s1) begin
			disc = $signed({2'b00, bb_s1}) - $signed({ac_s1, 2'b00});
		end else begin
			disc = $signed({2'b00, bb_s1}) + $signed({ac_s1, 2'b00});
		end
		if (a_s1 == '0) begin
			kind_c = (b_s1 != '0) ? KIND_LINEAR : KIND_NONE;
		end else if (disc[D_W-1]) begin
			kind_c = KIND_COMPLEX;
		end else if (disc == '0) begin
			kind_c = KIND_DOUBLE;
		end else begin
			kind_c = KIND_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= disc[D_W-1] ? RAD_W'(-disc) : RAD_W'(disc);
			side_s2 <= '{kind: kind_c, a: a_s1, b: b_s1, c: c_s1};
		end
	end

	// square root chain
	logic                sq_v    [0:SQ_W];
	logic [SQ_W+1:0]     sq_rem  [0:SQ_W];
	logic [SQ_W-1:0]     sq_root [0:SQ_W];
	logic [RAD_W-1:0]    sq_rad  [0:SQ_W];
	sq_side_t            sq_side [0:SQ_W];

	assign sq_v[0]    = v_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s2;
	assign sq_side[0] = side_s2;

	for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (sq_v[i]),
			.rem     (sq_rem[i]),
			.root    (sq_root[i]),
			.rad     (sq_rad[i]),
			.side    (sq_side[i]),
			.valid_q (sq_v[i+1]),
			.rem_q   (sq_rem[i+1]),
			.root_q  (sq_root[i+1]),
			.rad_q   (sq_rad[i+1]),
			.side_q  (sq_side[i+1])
		);
	end

	// stage 3: numerators, divisor and signs
	sq_side_t               sd;
	logic signed [NS_W-1:0] ax, bx, cx, sx, n1, n2, den;
	logic [NS_W-1:0]        n1m, n2m, denm;
	dv_side_t               dside_c;
	logic                   v_s3;
	logic [DEN_W-1:0]       dm_s3;
	logic [ND_W-1:0]        dvd1_s3, dvd2_s3;
	dv_side_t               dside_s3;

	always_comb begin
		sd   = sq_side[SQ_W];
		ax   = NS_W'(sd.a);
		bx   = NS_W'(sd.b);
		cx   = NS_W'(sd.c);
		sx   = $signed({2'b00, sq_root[SQ_W]});
		den  = ax <<< 1;
		n1   = -bx;
		n2   = '0;
		dside_c = '{kind: sd.kind, use1: 1'b1, use2: 1'b0, neg1: 1'b0, neg2: 1'b0};
		case (sd.kind)
			KIND_LINEAR: begin
				n1  = -cx;
				den = bx;
			end
			KIND_TWO: begin
				n1 = sx - bx;
				n2 = -bx - sx;
				dside_c.use2 = 1'b1;
			end
			KIND_DOUBLE: begin
				n1 = -bx;
			end
			KIND_COMPLEX: begin
				n1 = -bx;
				n2 = sx;
				dside_c.use2 = 1'b1;
			end
			default: begin
				dside_c.use1 = 1'b0;
			end
		endcase
		dside_c.neg1 = n1[NS_W-1] ^ den[NS_W-1];
		dside_c.neg2 = n2[NS_W-1] ^ den[NS_W-1];
		n1m  = n1[NS_W-1] ? NS_W'(-n1) : NS_W'(n1);
		n2m  = n2[NS_W-1] ? NS_W'(-n2) : NS_W'(n2);
		denm = den[NS_W-1] ? NS_W'(-den) : NS_W'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v[SQ_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s3    <= denm[DEN_W-1:0];
			dvd1_s3  <= {n1m[NUM_W-1:0], {FRAC_BITS{1'b0}}};
			dvd2_s3  <= {n2m[NUM_W-1:0], {FRAC_BITS{1'b0}}};
			dside_s3 <= dside_c;
		end
	end

	// divider chain
	logic              dv_v    [0:ND_W];
	logic [DEN_W-1:0]  dv_dm   [0:ND_W];
	dv_side_t          dv_side [0:ND_W];
	logic [DEN_W-1:0]  dv_rem1 [0:ND_W];
	logic [DEN_W-1:0]  dv_rem2 [0:ND_W];
	logic [ND_W-1:0]   dv_dvd1 [0:ND_W];
	logic [ND_W-1:0]   dv_dvd2 [0:ND_W];
	logic [ND_W-1:0]   dv_quo1 [0:ND_W];
	logic [ND_W-1:0]   dv_quo2 [0:ND_W];

	assign dv_v[0]    = v_s3;
	assign dv_dm[0]   = dm_s3;
	assign dv_side[0] = dside_s3;
	assign dv_rem1[0] = '0;
	assign dv_rem2[0] = '0;
	assign dv_dvd1[0] = dvd1_s3;
	assign dv_dvd2[0] = dvd2_s3;
	assign dv_quo1[0] = '0;
	assign dv_quo2[0] = '0;

	for (genvar j = 0; j < ND_W; j++) begin : g_div
		qrs_div_cell #(.ND_W(ND_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (dv_v[j]),
			.dm      (dv_dm[j]),
			.side    (dv_side[j]),
			.rem1    (dv_rem1[j]),
			.rem2    (dv_rem2[j]),
			.dvd1    (dv_dvd1[j]),
			.dvd2    (dv_dvd2[j]),
			.quo1    (dv_quo1[j]),
			.quo2    (dv_quo2[j]),
			.valid_q (dv_v[j+1]),
			.dm_q    (dv_dm[j+1]),
			.side_q  (dv_side[j+1]),
			.rem1_q  (dv_rem1[j+1]),
			.rem2_q  (dv_rem2[j+1]),
			.dvd1_q  (dv_dvd1[j+1]),
			.dvd2_q  (dv_dvd2[j+1]),
			.quo1_q  (dv_quo1[j+1]),
			.quo2_q  (dv_quo2[j+1])
		);
	end

	// clamp, apply sign and load the output register
	dv_side_t         fs;
	logic [ND_W-1:0]  lim_pos, lim1, lim2, m1, m2;
	logic             ov1, ov2;
	logic [VAL_W-1:0] r1, r2;

	always_comb begin
		fs      = dv_side[ND_W];
		lim_pos = {{(ND_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
		lim1    = fs.neg1 ? lim_pos + 1'b1 : lim_pos;
		lim2    = fs.neg2 ? lim_pos + 1'b1 : lim_pos;
		ov1     = fs.use1 && (dv_quo1[ND_W] > lim1);
		ov2     = fs.use2 && (dv_quo2[ND_W] > lim2);
		m1      = ov1 ? lim1 : dv_quo1[ND_W];
		m2      = ov2 ? lim2 : dv_quo2[ND_W];
		r1      = fs.neg1 ? (~m1[VAL_W-1:0] + 1'b1) : m1[VAL_W-1:0];
		r2      = fs.neg2 ? (~m2[VAL_W-1:0] + 1'b1) : m2[VAL_W-1:0];
		if (!fs.use1) begin
			r1 = '0;
		end
		if (!fs.use2) begin
			r2 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= dv_v[ND_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.root_kind    <= fs.kind;
			rsp_q.first_value  <= r1;
			rsp_q.second_value <= r2;
			rsp_q.saturated    <= ov1 || ov2;
		end
	end

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.root_kind <= KIND_COMPLEX))
		else $error("result class code out of range");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.root_kind == KIND_NONE) |->
		(rsp_q.first_value == '0 && rsp_q.second_value == '0 && !rsp_q.saturated))
		else $error("degenerate result carries nonzero values");

	a_single_root: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.root_kind == KIND_LINEAR || rsp_q.root_kind == KIND_DOUBLE))
		|-> (rsp_q.second_value == '0))
		else $error("single root result has nonzero second value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(dv_v[ND_W])))
		else $error("pipe moved while result beat stalled");

endmodule

// File: tb/tb_quadratic_root_solver_top.sv
// Self-checking testbench for quadratic_root_solver_top: random and corner coefficient sets.
// Depends on qrs_pkg and the solver RTL; a scoreboard class predicts each result beat.
`timescale 1ns / 1ps

import qrs_pkg::*;

class root_scoreboard;
	out_beat_t pending[$];
	int errors = 0;

	// floor(sqrt(m)) over an unsigned 128-bit radicand
	static function automatic logic [63:0] floor_sqrt(input logic [127:0] m);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if ({64'd0, t} * {64'd0, t} <= m)
				r = t;
		end
		return r;
	endfunction

	// trunc((num << 16) / den), clamped to the 32-bit range
	static function automatic logic [31:0] clamped_quot(input logic signed [63:0] num,
			input logic signed [63:0] den, inout logic sat);
		logic [63:0] nm;
		logic [63:0] dm;
		logic [127:0] q;
		logic [63:0] lim;
		logic neg;
		nm = num < 0 ? -num : num;
		dm = den < 0 ? -den : den;
		neg = (num < 0) != (den < 0);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (dm == 0) begin
			sat = 1'b1;
			return lim[31:0];
		end
		q = ({64'd0, nm} << FRAC_BITS_DEF) / {64'd0, dm};
		if (q > {64'd0, lim}) begin
			sat = 1'b1;
			q = {64'd0, lim};
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function void note_coefs(input in_beat_t x);
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] c;
		logic signed [127:0] d;
		logic signed [63:0] s;
		out_beat_t r;
		a = x.coef_a;
		b = x.coef_b;
		c = x.coef_c;
		r = '0;
		if (a == 0) begin
			if (b != 0) begin
				r.root_kind = KIND_LINEAR;
				r.first_value = clamped_quot(-c, b, r.saturated);
			end else
				r.root_kind = KIND_NONE;
		end else begin
			d = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
			if (d < 0) begin
				s = floor_sqrt(-d);
				r.root_kind = KIND_COMPLEX;
				r.first_value = clamped_quot(-b, 2 * a, r.saturated);
				r.second_value = clamped_quot(s, 2 * a, r.saturated);
			end else if (d == 0) begin
				r.root_kind = KIND_DOUBLE;
				r.first_value = clamped_quot(-b, 2 * a, r.saturated);
			end else begin
				s = floor_sqrt(d);
				r.root_kind = KIND_TWO;
				r.first_value = clamped_quot(-b + s, 2 * a, r.saturated);
				r.second_value = clamped_quot(-b - s, 2 * a, r.saturated);
			end
		end
		pending.push_back(r);
	endfunction

	function void check_roots(input out_beat_t got);
		out_beat_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result beat %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.root_kind !== e.root_kind) begin
			$display("%0t: root_kind exp %0d got %0d", $time, e.root_kind, got.root_kind);
			errors++;
		end
		if (got.first_value !== e.first_value) begin
			$display("%0t: first_value exp %h got %h", $time, e.first_value, got.first_value);
			errors++;
		end
		if (got.second_value !== e.second_value) begin
			$display("%0t: second_value exp %h got %h", $time, e.second_value,
				got.second_value);
			errors++;
		end
		if (got.saturated !== e.saturated) begin
			$display("%0t: saturated exp %0d got %0d", $time, e.saturated, got.saturated);
			errors++;
		end
	endfunction
endclass

module tb_quadratic_root_solver_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	in_beat_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_beat_t rsp;

	root_scoreboard board = new();
	in_beat_t coef_list[$];
	longint cycles = 0;
	int rsp_wait = 0;

	quadratic_root_solver_top DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// response side: check beats, then hold the next beat for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			board.check_roots(rsp);
			rsp_wait = $urandom_range(0, 5);
		end
		if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= 1'b0;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			4: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
			5: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_beat_t make_set(input int ra, input int rb, input int rc);
		in_beat_t x;
		x.coef_a = ra;
		x.coef_b = rb;
		x.coef_c = rc;
		return x;
	endfunction

	task automatic send_coefs(input in_beat_t x);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= x;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.note_coefs(x);
	endtask

	initial begin
		in_beat_t x;
		int lo;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// none, linear, two, double, complex, divide saturation, extremes
		coef_list.push_back(make_set(0, 0, 0));
		coef_list.push_back(make_set(0, 0, 32'h0003_0000));
		coef_list.push_back(make_set(0, 32'h0002_0000, 32'hFFFC_0000));
		coef_list.push_back(make_set(0, 1, 32'h7FFF_FFFF));
		coef_list.push_back(make_set(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000));
		coef_list.push_back(make_set(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000));
		coef_list.push_back(make_set(32'h0001_0000, 32'h0002_0000, 32'h0005_0000));
		coef_list.push_back(make_set(32'hFFFF_0000, 32'h0002_0000, 32'h0005_0000));
		coef_list.push_back(make_set(1, 32'h7FFF_FFFF, 1));
		coef_list.push_back(make_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		coef_list.push_back(make_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		coef_list.push_back(make_set(32'h8000_0000, 0, 32'h7FFF_FFFF));
		coef_list.push_back(make_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
		coef_list.push_back(make_set(1, 0, 1));
		coef_list.push_back(make_set(-1, 32'hFFFF_FFFF, 0));
		coef_list.push_back(make_set(0, 32'h8000_0000, 32'h8000_0000));
		foreach (coef_list[i])
			send_coefs(coef_list[i]);
		for (int n = 0; n < 500; n++) begin
			x.coef_a = $urandom_range(0, 5) == 0 ? 32'h0 : pick_value();
			x.coef_b = pick_value();
			x.coef_c = pick_value();
			// every fourth set: perfect square (x - r)^2 scaled, to reach the double root
			if (n % 4 == 0) begin
				lo = $signed($urandom_range(0, 64)) - 32;
				x.coef_a = 32'h0001_0000;
				x.coef_b = (-2 * lo) <<< 16;
				x.coef_c = (lo * lo) <<< 16;
			end
			send_coefs(x);
		end
		req_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_sqrt_cell.sv
hw/rtl/qrs_div_cell.sv
hw/rtl/quadratic_root_solver_top.sv
tb/tb_quadratic_root_solver_top.sv
